>>> rtl/ibn_pkg.sv
`default_nettype none

package ibn_pkg;

    // Data path and table geometry
    localparam int DATA_BITS    = 32;
    localparam int MAX_CHANNELS = 1024;
    localparam int CH_BITS      = $clog2(MAX_CHANNELS);
    localparam int POS_BITS     = 16;
    localparam int PS_BITS      = 17;
    localparam int CC_BITS      = 11;
    localparam int DIV_CNT_BITS = $clog2(DATA_BITS);

    // Limits of the tensor geometry
    localparam logic [PS_BITS-1:0] PS_MAX = PS_BITS'(65536);
    localparam logic [CC_BITS-1:0] CC_MAX = CC_BITS'(MAX_CHANNELS);

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd1;

    // Request opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic               sub_en;
        logic               mul_en;
        logic               div_start;
        logic               out_en;
        logic [CH_BITS-1:0] rd_addr;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/ibn_div.sv
`default_nettype none

module ibn_div
    import ibn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DATA_BITS-1:0] i_num,
    input  wire logic [DATA_BITS-1:0] i_den,
    output logic                      o_done,
    output logic [DATA_BITS-1:0]      o_quo
);

    logic                    r_busy;
    logic                    r_fix;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DATA_BITS-1:0]    r_rem;
    logic [DATA_BITS-1:0]    r_quo;
    logic [DATA_BITS-1:0]    r_dv;
    logic                    r_neg;
    logic [DATA_BITS-1:0]    r_q;

    logic                    num_neg;
    logic                    den_neg;
    logic [DATA_BITS-1:0]    num_abs;
    logic [DATA_BITS-1:0]    den_abs;
    logic [DATA_BITS:0]      trial;
    logic [DATA_BITS:0]      diff;
    logic                    fits;

    // Operand magnitudes; a zero divisor divides by one
    always_comb begin
        num_neg = i_num[DATA_BITS-1];
        den_neg = i_den[DATA_BITS-1];
        num_abs = num_neg ? (~i_num + DATA_BITS'(1)) : i_num;
        den_abs = den_neg ? (~i_den + DATA_BITS'(1)) : i_den;
        if (den_abs == '0) begin
            den_abs = DATA_BITS'(1);
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DATA_BITS-1]};
        diff  = trial - {1'b0, r_dv};
        fits  = (trial >= {1'b0, r_dv});
    end

    // Control: load, one quotient bit per cycle, then sign fix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fix;
            r_fix  <= r_busy && !i_start && (r_cnt == DIV_CNT_BITS'(DATA_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(DATA_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder, quotient and sign registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= num_abs;
            r_dv  <= den_abs;
            r_neg <= num_neg ^ den_neg;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
            r_quo <= {r_quo[DATA_BITS-2:0], fits};
        end
        if (r_fix) begin
            r_q <= r_neg ? (~r_quo + DATA_BITS'(1)) : r_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

>>> rtl/ibn_dpath.sv
`default_nettype none

module ibn_dpath
    import ibn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [CH_BITS-1:0]   i_param_channel,
    input  wire logic [DATA_BITS-1:0] i_bias,
    input  wire logic [DATA_BITS-1:0] i_mean,
    input  wire logic [DATA_BITS-1:0] i_variance,
    input  wire logic [DATA_BITS-1:0] i_weight,
    input  wire logic [DATA_BITS-1:0] i_sample,
    output logic [DATA_BITS-1:0]      o_result
);

    localparam int ROW_BITS = 4 * DATA_BITS;

    // Row layout: {bias, mean, divisor, weight}
    logic [ROW_BITS-1:0]    r_mem [0:MAX_CHANNELS-1];
    logic [ROW_BITS-1:0]    r_rd;
    logic [DATA_BITS-1:0]   r_sample;
    logic [DATA_BITS-1:0]   r_x;
    logic [DATA_BITS-1:0]   r_result;

    logic [DATA_BITS-1:0]   wr_div;
    logic [DATA_BITS-1:0]   rd_bias;
    logic [DATA_BITS-1:0]   rd_mean;
    logic [DATA_BITS-1:0]   rd_div;
    logic [DATA_BITS-1:0]   rd_weight;
    logic [2*DATA_BITS-1:0] prod;
    logic                   div_done;
    logic [DATA_BITS-1:0]   div_quo;

    assign wr_div    = (i_variance == '0) ? DATA_BITS'(1) : i_variance;
    assign rd_bias   = r_rd[4*DATA_BITS-1:3*DATA_BITS];
    assign rd_mean   = r_rd[3*DATA_BITS-1:2*DATA_BITS];
    assign rd_div    = r_rd[2*DATA_BITS-1:DATA_BITS];
    assign rd_weight = r_rd[DATA_BITS-1:0];
    assign prod      = r_x * rd_weight;

    // Parameter table: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_param_channel] <= {i_bias, i_mean, wr_div, i_weight};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    // Subtract mean, scale by weight, add bias after the divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_sample <= i_sample;
        end
        if (i_cmd.sub_en) begin
            r_x <= r_sample - rd_mean;
        end else if (i_cmd.mul_en) begin
            r_x <= prod[DATA_BITS-1:0];
        end
        if (i_cmd.out_en) begin
            r_result <= div_quo + rd_bias;
        end
    end

    ibn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_x),
        .i_den   (rd_div),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_sts.div_done = div_done;
    assign o_result       = r_result;

endmodule

`default_nettype wire

>>> rtl/ibn_ctrl.sv
`default_nettype none

module ibn_ctrl
    import ibn_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_op,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_dp_cmd                       o_cmd,
    input  wire t_dp_sts                  i_sts,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [CH_BITS-1:0]            o_channel,
    output logic                          o_last_of_tensor
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [PS_BITS-1:0]  r_plane;
    logic [CC_BITS-1:0]  r_chans;
    logic [POS_BITS-1:0] r_pos;
    logic [CH_BITS-1:0]  r_cur_ch;
    logic [CH_BITS-1:0]  r_item_ch;
    logic                r_item_last;
    logic                r_o_valid;
    logic [CH_BITS-1:0]  r_o_channel;
    logic                r_o_last;

    logic [PS_BITS-1:0]  ps_eff;
    logic [CC_BITS-1:0]  cc_eff;
    logic [PS_BITS-1:0]  pos_inc;
    logic [CC_BITS-1:0]  ch_inc;
    logic                accept;
    logic                plane_end;
    logic                tensor_end;
    logic                out_load;

    // Geometry clamped to its legal range
    always_comb begin
        priority if (r_plane == '0) begin
            ps_eff = PS_BITS'(1);
        end else if (r_plane > PS_MAX) begin
            ps_eff = PS_MAX;
        end else begin
            ps_eff = r_plane;
        end
        priority if (r_chans == '0) begin
            cc_eff = CC_BITS'(1);
        end else if (r_chans > CC_MAX) begin
            cc_eff = CC_MAX;
        end else begin
            cc_eff = r_chans;
        end
    end

    // Position tracking inside the tensor
    assign pos_inc    = {1'b0, r_pos} + PS_BITS'(1);
    assign ch_inc     = {1'b0, r_cur_ch} + CC_BITS'(1);
    assign plane_end  = (pos_inc >= ps_eff);
    assign tensor_end = plane_end && (ch_inc >= cc_eff);

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_o_valid || !i_stall);

    // Datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_en     = accept && (i_op == OP_LOAD);
        o_cmd.rd_en     = accept && (i_op == OP_SAMPLE);
        o_cmd.sub_en    = (r_state == S_SUB);
        o_cmd.mul_en    = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.out_en    = out_load;
        o_cmd.rd_addr   = r_cur_ch;
    end

    // State machine, counters, config and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plane     <= PS_BITS'(1);
            r_chans     <= CC_BITS'(1);
            r_pos       <= '0;
            r_cur_ch    <= '0;
            r_item_ch   <= '0;
            r_item_last <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_channel <= '0;
            r_o_last    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == OP_SAMPLE)) begin
                        r_state     <= S_SUB;
                        r_item_ch   <= r_cur_ch;
                        r_item_last <= tensor_end;
                        if (plane_end) begin
                            r_pos <= '0;
                            r_cur_ch <= tensor_end ? '0 : ch_inc[CH_BITS-1:0];
                        end else begin
                            r_pos <= pos_inc[POS_BITS-1:0];
                        end
                    end
                end
                S_SUB:    r_state <= S_MUL;
                S_MUL:    r_state <= S_DSTART;
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Output register
            if (out_load) begin
                r_o_valid   <= 1'b1;
                r_o_channel <= r_item_ch;
                r_o_last    <= r_item_last;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            // Writes to plane size or channel count restart the tensor
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PLANE_SIZE: begin
                        r_plane  <= i_cfg_data[PS_BITS-1:0];
                        r_pos    <= '0;
                        r_cur_ch <= '0;
                    end
                    CFG_CHANNEL_COUNT: begin
                        r_chans  <= i_cfg_data[CC_BITS-1:0];
                        r_pos    <= '0;
                        r_cur_ch <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_channel        = r_o_channel;
    assign o_last_of_tensor = r_o_last;

    // Position stays inside the current plane
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < ps_eff))
        else $error("plane position out of range");

    // Channel stays inside the tensor
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur_ch} < cc_eff))
        else $error("channel out of range");

    // A sample request starts the datapath sequence
    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_SAMPLE)) |=> (r_state == S_SUB))
        else $error("sample request did not start processing");

    // A load request leaves the controller idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_LOAD) && !i_cfg_we) |=> (r_state == S_IDLE))
        else $error("load request left idle");

    // A new result appears only from the output state
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result valid without finished divide");

endmodule

`default_nettype wire

>>> rtl/integer_batchnorm_affine_top.sv
// Integer batch normalization: result = ((sample - mean) * weight) / divisor + bias.
// Load request: accepted while idle, writes one row of the parameter table.
// Sample request: subtract mean, multiply, divide, add bias; new requests stall until the result
// is loaded; the radix-2 divider gives one quotient bit per cycle over 32 bits, plus sign fix.
// The output register holds a result while the next request is accepted.
// Synchronous active-low reset resets control, position and geometry; tables are not cleared.
`default_nettype none

module integer_batchnorm_affine_top
    import ibn_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_op,
    input  wire logic [CH_BITS-1:0]       i_param_channel,
    input  wire logic signed [31:0]       i_bias,
    input  wire logic signed [31:0]       i_mean,
    input  wire logic signed [31:0]       i_variance,
    input  wire logic signed [31:0]       i_weight,
    input  wire logic signed [31:0]       i_sample,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [31:0]            o_result,
    output logic [CH_BITS-1:0]            o_channel,
    output logic                          o_last_of_tensor
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [DATA_BITS-1:0] result;

    ibn_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_cmd            (cmd),
        .i_sts            (sts),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_channel        (o_channel),
        .o_last_of_tensor (o_last_of_tensor)
    );

    ibn_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_param_channel (i_param_channel),
        .i_bias          (DATA_BITS'(i_bias)),
        .i_mean          (DATA_BITS'(i_mean)),
        .i_variance      (DATA_BITS'(i_variance)),
        .i_weight        (DATA_BITS'(i_weight)),
        .i_sample        (DATA_BITS'(i_sample)),
        .o_result        (result)
    );

    assign o_result = 32'(signed'(result));

endmodule

`default_nettype wire
